@@ hw/rtl/sps_pkg.sv @@
// shared constants and types for the sensor presence stabilizer
`default_nettype none

package sps_pkg;

  // datapath widths
  localparam int unsigned FREQ_BITS  = 32;
  localparam int unsigned SUM_BITS   = 40;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // filter arithmetic: weights in 1/256 units
  localparam int unsigned FILT_SHIFT = 8;
  localparam int unsigned WEIGHT_W   = FILT_SHIFT + 1;
  localparam int unsigned PROD_W     = FREQ_BITS + 1 + WEIGHT_W + 1;
  localparam logic [WEIGHT_W-1:0] FILT_ONE    = WEIGHT_W'(1 << FILT_SHIFT);
  // stabilization retention of 0.3 is 77/256, so the update weight is 179/256
  localparam logic [WEIGHT_W-1:0] STAB_WEIGHT = WEIGHT_W'(179);
  localparam int unsigned ROUND_ADJ = (1 << FILT_SHIFT) - 1;

  // divider step counter
  localparam int unsigned DIV_CNT_W = $clog2(SUM_BITS + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_BITS - 1);

  // operating modes
  localparam logic [MODE_W-1:0] MODE_SLEEP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STAB    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACTIVE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLOCKED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_RUN       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_RUN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_RUN      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_K       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_TOP_BIT   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE      = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_CLOCK = 8'd7;

  // divider request and response
  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [RUN_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

  // event pulses carried with one result word
  typedef struct packed {
    logic start_beat;
    logic stop_beat;
    logic silence_notes;
    logic stop_all;
  } events_t;

endpackage

`default_nettype wire

@@ hw/rtl/sps_if.sv @@
// valid/ready channel interfaces for samples, results and register writes
`default_nettype none

interface sps_in_if import sps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample_freq;

  modport source (output valid, output sample_freq, input ready);
  modport sink (input valid, input sample_freq, output ready);
endinterface

interface sps_out_if import sps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [OUT_W-1:0]  filtered_freq;
  logic [OUT_W-1:0]  mean_freq;
  logic [OUT_W-1:0]  mean_deviation;
  logic              start_beat;
  logic              stop_beat;
  logic              silence_notes;
  logic              stop_all;

  modport source (output valid, output mode, output filtered_freq, output mean_freq,
                  output mean_deviation, output start_beat, output stop_beat,
                  output silence_notes, output stop_all, input ready);
  modport sink (input valid, input mode, input filtered_freq, input mean_freq,
                input mean_deviation, input start_beat, input stop_beat,
                input silence_notes, input stop_all, output ready);
endinterface

interface sps_cfg_if import sps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sps_div.sv @@
// shared restoring divider: sum by run count, one quotient bit per cycle
`default_nettype none

module sps_div import sps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RUN_W-1:0]     rem_q, rem_d;
  logic [RUN_W-1:0]     dvs_q, dvs_d;
  logic [SUM_BITS-1:0]  quo_q, quo_d;

  logic [RUN_W:0] trial;
  logic [RUN_W:0] trial_sub;
  logic           fits;

  // one restoring step: shift in the next dividend bit and try a subtract
  assign trial     = {rem_q, quo_q[SUM_BITS-1]};
  assign fits      = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[RUN_W-1:0] : trial[RUN_W-1:0];
      quo_d = {quo_q[SUM_BITS-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/sensor_presence_stabilizer_core.sv @@
// top level of the sensor presence stabilizer
// Usage: one frequency sample word enters on in_ch and exactly one result word
// leaves on out_ch, carrying the mode after the sample, the filtered and mean
// values (zero outside the two active modes) and the beat/note/stop pulses.
// Registers are written through cfg (index, data), always ready; the user
// must write them only while the block is idle; the block does not enforce
// this. Samples are handled one at a time by a small sequencer around a
// shared multiplier step and a shared bit-serial divider. States before OUT:
//   sleep, aborted stabilization: EVAL
//   unfiltered active or a sample loaded into an empty filter: EVAL, POST
//   filtered sample (one multiply and one add step): EVAL, MUL, FILT, POST
//   last stabilization sample: then DIVL and DIVD, which wait on the
//   two divisions through the one divider, one quotient bit per cycle
// A new sample is taken in the cycle after the result is loaded into the
// output register, so one sample is accepted while a result still waits.
// If the receiver stalls, the finished result holds and the sequencer waits
// with its next result until the output register frees up.
// Reset puts the block in sleep with all sums, counts and filter cleared and
// the registers at their defaults; no clearing pass is needed.
`default_nettype none

module sensor_presence_stabilizer_core import sps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sps_cfg_if.sink   cfg,
  sps_in_if.sink    in_ch,
  sps_out_if.source out_ch
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_FILT = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;
  localparam logic [2:0] ST_DIVL = 3'd5;
  localparam logic [2:0] ST_DIVD = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // configuration registers
  logic [31:0]      min_level_q;
  logic [RUN_W-1:0] wake_run_q;
  logic [RUN_W-1:0] average_run_q;
  logic [RUN_W-1:0] sleep_run_q;
  logic [7:0]       filter_k_q;
  logic             keep_top_bit_q;
  logic             test_mode_q;
  logic             external_clock_q;

  // block state
  logic [2:0]           state_q, state_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [RUN_W-1:0]     run_q, run_d;
  logic [FREQ_BITS-1:0] filt_q, filt_d;
  logic [FREQ_BITS-1:0] ref_q, ref_d;
  logic [SUM_BITS-1:0]  lsum_q, lsum_d;
  logic [SUM_BITS-1:0]  dsum_q, dsum_d;
  events_t              ev_q, ev_d;

  // working registers
  logic [FREQ_BITS-1:0]     x_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [MODE_W-1:0] out_mode_q, out_mode_d;
  logic [OUT_W-1:0]  out_filt_q, out_filt_d;
  logic [OUT_W-1:0]  out_mean_q, out_mean_d;
  logic [OUT_W-1:0]  out_dev_q, out_dev_d;
  events_t           out_ev_q, out_ev_d;

  // divider link
  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic                     in_acc;
  logic [31:0]              x_ext;
  logic                     x_hi;
  logic                     x_lo;
  logic [RUN_W-1:0]         run_inc;
  logic [RUN_W-1:0]         run_wake;
  logic [FREQ_BITS-1:0]     abs_dev;
  logic signed [FREQ_BITS:0] diff_s;
  logic [WEIGHT_W-1:0]      weight;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] step_s;
  logic [FREQ_BITS-1:0]     filt_new;
  logic [SUM_BITS-1:0]      lsum_add;
  logic                     out_act;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign cfg.ready = 1'b1;

  // sample compares and counters
  assign x_ext    = 32'(x_q);
  assign x_hi     = x_ext > min_level_q;
  assign x_lo     = x_ext < min_level_q;
  assign run_inc  = run_q + 1'b1;
  assign run_wake = x_hi ? run_inc : '0;
  assign abs_dev  = (ref_q > x_q) ? (ref_q - x_q) : (x_q - ref_q);
  assign lsum_add = lsum_q + SUM_BITS'(filt_q);

  // low-pass step: f + trunc((x - f) * w / 256)
  assign diff_s   = $signed({1'b0, x_q}) - $signed({1'b0, filt_q});
  assign weight   = (mode_q == MODE_STAB) ? STAB_WEIGHT
                                          : (FILT_ONE - WEIGHT_W'(filter_k_q));
  assign prod_rnd = prod_q[PROD_W-1] ? (prod_q + PROD_W'(ROUND_ADJ)) : prod_q;
  assign step_s   = prod_rnd >>> FILT_SHIFT;

  always_comb begin
    filt_new = filt_q + step_s[FREQ_BITS-1:0];
    if (!keep_top_bit_q) begin
      filt_new[FREQ_BITS-1] = 1'b0;
    end
  end

  assign out_act = (mode_q == MODE_ACTIVE) || (mode_q == MODE_CLOCKED);

  // sequencer
  always_comb begin
    state_d          = state_q;
    mode_d           = mode_q;
    run_d            = run_q;
    filt_d           = filt_q;
    ref_d            = ref_q;
    lsum_d           = lsum_q;
    dsum_d           = dsum_q;
    ev_d             = ev_q;
    prod_d           = prod_q;
    div_req.start    = 1'b0;
    div_req.dividend = lsum_add;
    div_req.divisor  = run_q;
    out_valid_d      = out_valid_q;
    out_mode_d       = out_mode_q;
    out_filt_d       = out_filt_q;
    out_mean_d       = out_mean_q;
    out_dev_d        = out_dev_q;
    out_ev_d         = out_ev_q;

    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ev_d    = '0;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        case (mode_q)
          MODE_SLEEP: begin
            if (!test_mode_q) begin
              run_d = run_wake;
              if (run_wake >= wake_run_q) begin
                mode_d = MODE_STAB;
                run_d  = '0;
              end
            end
            state_d = ST_OUT;
          end
          MODE_STAB: begin
            if (x_hi && !test_mode_q) begin
              run_d = run_inc;
              // first sample of a run sets the reference and adds no deviation
              if (run_q == '0) begin
                ref_d = x_q;
              end else begin
                dsum_d = dsum_q + SUM_BITS'(abs_dev);
              end
              if (filt_q == '0) begin
                filt_d  = x_q;
                state_d = ST_POST;
              end else begin
                state_d = ST_MUL;
              end
            end else begin
              run_d              = '0;
              dsum_d             = '0;
              lsum_d             = '0;
              ref_d              = '0;
              ev_d.silence_notes = 1'b1;
              mode_d             = MODE_SLEEP;
              state_d            = ST_OUT;
            end
          end
          default: begin
            run_d = x_lo ? run_inc : '0;
            if (filter_k_q != '0) begin
              if (filt_q == '0) begin
                filt_d  = x_q;
                state_d = ST_POST;
              end else begin
                state_d = ST_MUL;
              end
            end else begin
              state_d = ST_POST;
            end
          end
        endcase
      end

      ST_MUL: begin
        prod_d  = PROD_W'(diff_s) * PROD_W'($signed({1'b0, weight}));
        state_d = ST_FILT;
      end

      ST_FILT: begin
        filt_d  = filt_new;
        state_d = ST_POST;
      end

      ST_POST: begin
        if (mode_q == MODE_STAB) begin
          lsum_d = lsum_add;
          if (run_q > average_run_q) begin
            div_req.start = 1'b1;
            state_d       = ST_DIVL;
          end else begin
            state_d = ST_OUT;
          end
        end else begin
          ref_d = (filter_k_q != '0) ? filt_q : x_q;
          if ((run_q > sleep_run_q) || test_mode_q) begin
            run_d          = '0;
            ref_d          = '0;
            lsum_d         = '0;
            dsum_d         = '0;
            filt_d         = '0;
            ev_d.stop_beat = (mode_q == MODE_ACTIVE);
            ev_d.stop_all  = 1'b1;
            mode_d         = MODE_SLEEP;
          end
          state_d = ST_OUT;
        end
      end

      ST_DIVL: begin
        if (div_rsp.done) begin
          lsum_d           = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = dsum_q;
          state_d          = ST_DIVD;
        end
      end

      ST_DIVD: begin
        if (div_rsp.done) begin
          dsum_d             = div_rsp.quotient;
          run_d              = '0;
          ev_d.silence_notes = 1'b1;
          if (external_clock_q) begin
            mode_d = MODE_CLOCKED;
          end else begin
            mode_d          = MODE_ACTIVE;
            ev_d.start_beat = 1'b1;
          end
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_mode_d  = mode_q;
          out_filt_d  = out_act ? OUT_W'(ref_q) : '0;
          out_mean_d  = out_act ? OUT_W'(lsum_q) : '0;
          out_dev_d   = out_act ? OUT_W'(dsum_q) : '0;
          out_ev_d    = ev_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // shared divider
  sps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q      <= '0;
      wake_run_q       <= 8'd10;
      average_run_q    <= 8'd50;
      sleep_run_q      <= 8'd50;
      filter_k_q       <= '0;
      keep_top_bit_q   <= 1'b0;
      test_mode_q      <= 1'b0;
      external_clock_q <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MIN_LEVEL:      min_level_q      <= cfg.data;
        CFG_WAKE_RUN:       wake_run_q       <= cfg.data[RUN_W-1:0];
        CFG_AVERAGE_RUN:    average_run_q    <= cfg.data[RUN_W-1:0];
        CFG_SLEEP_RUN:      sleep_run_q      <= cfg.data[RUN_W-1:0];
        CFG_FILTER_K:       filter_k_q       <= cfg.data[7:0];
        CFG_KEEP_TOP_BIT:   keep_top_bit_q   <= cfg.data[0];
        CFG_TEST_MODE:      test_mode_q      <= cfg.data[0];
        CFG_EXTERNAL_CLOCK: external_clock_q <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SLEEP;
      run_q       <= '0;
      filt_q      <= '0;
      ref_q       <= '0;
      lsum_q      <= '0;
      dsum_q      <= '0;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      run_q       <= run_d;
      filt_q      <= filt_d;
      ref_q       <= ref_d;
      lsum_q      <= lsum_d;
      dsum_q      <= dsum_d;
      ev_q        <= ev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_ch.sample_freq[FREQ_BITS-1:0];
    end
    prod_q     <= prod_d;
    out_mode_q <= out_mode_d;
    out_filt_q <= out_filt_d;
    out_mean_q <= out_mean_d;
    out_dev_q  <= out_dev_d;
    out_ev_q   <= out_ev_d;
  end

  // result word
  assign out_ch.valid          = out_valid_q;
  assign out_ch.mode           = out_mode_q;
  assign out_ch.filtered_freq  = out_filt_q;
  assign out_ch.mean_freq      = out_mean_q;
  assign out_ch.mean_deviation = out_dev_q;
  assign out_ch.start_beat     = out_ev_q.start_beat;
  assign out_ch.stop_beat      = out_ev_q.stop_beat;
  assign out_ch.silence_notes  = out_ev_q.silence_notes;
  assign out_ch.stop_all       = out_ev_q.stop_all;

  // checks
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EVAL))
    else $error("accepted word not evaluated next");

  a_start_beat_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.start_beat) |-> (out_ch.mode == MODE_ACTIVE))
    else $error("start beat without active mode");

  a_stop_all_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.stop_all) |-> (out_ch.mode == MODE_SLEEP))
    else $error("stop all without sleep mode");

endmodule

`default_nettype wire
